/* rtl/rsum_pkg.sv */
`default_nettype none

package rsum_pkg;

    // Tree geometry
    localparam int LEAVES = 1024;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 64;
    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);
    // Node pointer with one spare bit so l can step past the last node
    localparam int PTR_W  = NODE_W + 1;

    // Beat layout
    localparam int S_TDATA_W = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_SUM = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_WR,
        ST_SET_ADD,
        ST_Q_L,
        ST_Q_L_ADD,
        ST_Q_R,
        ST_Q_R_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_L,
        RD_R,
        RD_SIB
    } rd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    clr_wr;
        logic    set_wr;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    set_add;
        logic    l_add;
        logic    r_add;
        logic    shift;
        logic    out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_sum;
        logic set_ok;
        logic range_empty;
        logic l_gt_r;
        logic l_odd;
        logic r_even;
        logic cur_root;
        logic clr_last;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/rsum_dp.sv */
`default_nettype none

module rsum_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rsum_pkg::cmd_t                 cmd,
    output rsum_pkg::stat_t                     stat,
    input  wire logic                           in_func,
    input  wire logic [rsum_pkg::IDX_W-1:0]     in_first,
    input  wire logic [rsum_pkg::IDX_W-1:0]     in_last,
    input  wire logic [rsum_pkg::DATA_W-1:0]    in_value,
    output logic [rsum_pkg::DATA_W-1:0]         out_total
);
    import rsum_pkg::*;

    logic [DATA_W-1:0] mem [NODES];

    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0]  l_reg, l_next;
    logic [PTR_W-1:0]  r_reg, r_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] out_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] add_opnd;
    logic [DATA_W-1:0] acc_sum;
    logic [PTR_W-1:0]  r_dec;

    logic [IDX_W-1:0]  last_sat;
    logic [PTR_W-1:0]  first_node;
    logic [PTR_W-1:0]  last_node;
    logic [NODE_W-1:0] rd_addr;
    logic [NODE_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;

    // Decode the incoming beat
    always_comb begin
        if (PTR_W'(in_last) >= PTR_W'(LEAVES)) begin
            last_sat = IDX_W'(LEAVES - 1);
        end else begin
            last_sat = in_last;
        end
        first_node = PTR_W'(in_first) + PTR_W'(LEAVES);
        last_node  = PTR_W'(last_sat) + PTR_W'(LEAVES);
    end

    assign stat.is_sum      = (in_func == FUNC_SUM);
    assign stat.set_ok      = (PTR_W'(in_first) < PTR_W'(LEAVES));
    assign stat.range_empty = (in_first > last_sat);
    assign stat.l_gt_r      = (l_reg > r_reg);
    assign stat.l_odd       = l_reg[0];
    assign stat.r_even      = ~r_reg[0];
    assign stat.cur_root    = (cur_reg == PTR_W'(1));
    assign stat.clr_last    = (clr_cnt_reg == NODE_W'(NODES - 1));

    // Shared accumulator adder
    assign add_opnd = cmd.set_add ? val_reg : acc_reg;
    assign acc_sum  = add_opnd + rd_data_reg;
    assign r_dec    = r_reg - PTR_W'(1);

    // Update walk registers
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        cur_next     = cur_reg;
        val_next     = val_reg;
        acc_next     = acc_reg;
        if (cmd.clr_wr) begin
            clr_cnt_next = clr_cnt_reg + NODE_W'(1);
        end
        if (cmd.load) begin
            l_next   = first_node;
            r_next   = last_node;
            cur_next = first_node;
            val_next = in_value;
            acc_next = '0;
        end
        if (cmd.set_add) begin
            val_next = acc_sum;
            cur_next = cur_reg >> 1;
        end
        if (cmd.l_add) begin
            acc_next = acc_sum;
            l_next   = l_reg + PTR_W'(1);
        end
        if (cmd.r_add) begin
            acc_next = acc_sum;
            r_next   = r_dec >> 1;
            l_next   = l_reg >> 1;
        end
        if (cmd.shift) begin
            r_next = r_reg >> 1;
            l_next = l_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        cur_reg <= cur_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
        if (cmd.out_load) begin
            out_reg <= acc_reg;
        end
    end

    // Node memory ports
    always_comb begin
        case (cmd.rd_sel)
            RD_L:    rd_addr = l_reg[NODE_W-1:0];
            RD_R:    rd_addr = r_reg[NODE_W-1:0];
            RD_SIB:  rd_addr = cur_reg[NODE_W-1:0] ^ NODE_W'(1);
            default: rd_addr = l_reg[NODE_W-1:0];
        endcase
        wr_en = cmd.clr_wr | cmd.set_wr;
        if (cmd.clr_wr) begin
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else begin
            wr_addr = cur_reg[NODE_W-1:0];
            wr_data = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_total = out_reg;

endmodule

`default_nettype wire

/* rtl/rsum_ctrl.sv */
`default_nettype none

module rsum_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire rsum_pkg::stat_t  stat,
    output rsum_pkg::cmd_t        cmd
);
    import rsum_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = ~m_valid_reg | m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.is_sum) begin
                        state_next = stat.range_empty ? ST_DONE : ST_Q_L;
                    end else if (stat.set_ok) begin
                        state_next = ST_SET_WR;
                    end
                end
            end
            ST_SET_WR: begin
                state_next = stat.cur_root ? ST_IDLE : ST_SET_ADD;
            end
            ST_SET_ADD: begin
                state_next = ST_SET_WR;
            end
            ST_Q_L: begin
                if (stat.l_gt_r) begin
                    state_next = ST_DONE;
                end else if (stat.l_odd) begin
                    state_next = ST_Q_L_ADD;
                end else begin
                    state_next = ST_Q_R;
                end
            end
            ST_Q_L_ADD: begin
                state_next = ST_Q_R;
            end
            ST_Q_R: begin
                state_next = stat.r_even ? ST_Q_R_ADD : ST_Q_L;
            end
            ST_Q_R_ADD: begin
                state_next = ST_Q_L;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.rd_sel = RD_L;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SET_WR: begin
                cmd.set_wr = 1'b1;
                cmd.rd_en  = ~stat.cur_root;
                cmd.rd_sel = RD_SIB;
            end
            ST_SET_ADD: begin
                cmd.set_add = 1'b1;
            end
            ST_Q_L: begin
                cmd.rd_en  = ~stat.l_gt_r & stat.l_odd;
                cmd.rd_sel = RD_L;
            end
            ST_Q_L_ADD: begin
                cmd.l_add = 1'b1;
            end
            ST_Q_R: begin
                cmd.rd_en  = stat.r_even;
                cmd.rd_sel = RD_R;
                cmd.shift  = ~stat.r_even;
            end
            ST_Q_R_ADD: begin
                cmd.r_add = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd.rd_sel = RD_L;
            end
        endcase
    end

    // Result valid: set on load, drop once the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

/* rtl/range_sum_tree.sv */
`default_nettype none

// Channel  | Dir | Ports                     | Beat contents (low bit up)
// s_       | in  | s_tvalid/s_tready         | tdata: first_index, last_index, leaf_value
//          |     | s_tuser                   | tuser: func (0 set, 1 sum)
// m_       | out | m_tvalid/m_tready         | tdata: range_total
//
// One item at a time through a single node memory (one write, one read port).
// A set writes the leaf and each parent up to the root: a write state per level and,
// below the root, an add state. A sum checks l and r at each level and adds a node
// for each side that takes one; an empty range goes straight to its end, where a
// sum may wait for the result beat to be taken. After reset a clearing pass writes zero
// to all 2*LEAVES nodes with s_tready low. A held result stalls only the next sum, at its end.

module range_sum_tree (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // first_index[9:0], last_index[19:10], leaf_value[83:20], zero pad
    input  wire logic [rsum_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[0]
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // range_total[63:0]
    output logic [rsum_pkg::M_TDATA_W-1:0]         m_tdata
);
    import rsum_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [DATA_W-1:0] total;

    rsum_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsum_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tuser[0]),
        .in_first  (s_tdata[IDX_W-1:0]),
        .in_last   (s_tdata[2*IDX_W-1:IDX_W]),
        .in_value  (s_tdata[2*IDX_W+DATA_W-1:2*IDX_W]),
        .out_total (total)
    );

    assign m_tdata = M_TDATA_W'(total);

endmodule

`default_nettype wire
